@@ rtl/core/apsp_pkg.sv @@
// apsp_pkg: command codes, microcode format and control ROM of the
// all-pairs shortest path block. No dependencies.
`default_nettype none

package apsp_pkg;

  // Command codes of an input transaction
  localparam logic [1:0] CMD_LOAD = 2'd0;
  localparam logic [1:0] CMD_RUN  = 2'd1;
  localparam logic [1:0] CMD_READ = 2'd2;

  // Matrix entry: infinity flag on top of a 16-bit distance
  localparam int DistW  = 16;
  localparam int EntryW = DistW + 1;

  // Memory read address selection
  localparam logic [1:0] AS_HOST = 2'd0;
  localparam logic [1:0] AS_IK   = 2'd1;
  localparam logic [1:0] AS_KJ   = 2'd2;
  localparam logic [1:0] AS_IJ   = 2'd3;

  // Jump conditions
  localparam logic [2:0] JC_NEXT     = 3'd0;
  localparam logic [2:0] JC_ALWAYS   = 3'd1;
  localparam logic [2:0] JC_ZERO     = 3'd2;
  localparam logic [2:0] JC_MORE     = 3'd3;
  localparam logic [2:0] JC_DISPATCH = 3'd4;

  // Step addresses of the control program
  localparam int StepW = 3;
  localparam logic [StepW-1:0] S_IDLE = 3'd0;
  localparam logic [StepW-1:0] S_INIT = 3'd1;
  localparam logic [StepW-1:0] S_RIK  = 3'd2;
  localparam logic [StepW-1:0] S_RKJ  = 3'd3;
  localparam logic [StepW-1:0] S_RIJ  = 3'd4;
  localparam logic [StepW-1:0] S_UPD  = 3'd5;
  localparam logic [StepW-1:0] S_DONE = 3'd6;
  localparam logic [StepW-1:0] S_RD   = 3'd7;

  typedef struct packed {
    logic       host;       // step takes host transactions
    logic [1:0] addr_sel;
    logic       mem_re;
    logic       lat_ik;
    logic       lat_kj;
    logic       upd_we;     // write back if the path via k is shorter
    logic       cnt_clr;
    logic       cnt_adv;
    logic       emit_rd;
    logic       emit_done;
  } ctrl_t;

  typedef struct packed {
    ctrl_t            ctrl;
    logic [2:0]       jc;
    logic [StepW-1:0] target;
  } ucode_t;

  typedef struct packed {
    logic n_zero;
    logic loop_more;
    logic out_free;
  } stat_t;

  function automatic ucode_t ucode_rom(input logic [StepW-1:0] step);
    ucode_t uc;
    uc = '0;
    case (step)
      S_IDLE: begin
        uc.ctrl.host     = 1'b1;
        uc.ctrl.addr_sel = AS_HOST;
        uc.ctrl.mem_re   = 1'b1;
        uc.jc            = JC_DISPATCH;
      end
      S_INIT: begin
        uc.ctrl.cnt_clr = 1'b1;
        uc.jc           = JC_ZERO;
        uc.target       = S_DONE;
      end
      S_RIK: begin
        uc.ctrl.addr_sel = AS_IK;
        uc.ctrl.mem_re   = 1'b1;
        uc.jc            = JC_NEXT;
      end
      S_RKJ: begin
        uc.ctrl.addr_sel = AS_KJ;
        uc.ctrl.mem_re   = 1'b1;
        uc.ctrl.lat_ik   = 1'b1;
        uc.jc            = JC_NEXT;
      end
      S_RIJ: begin
        uc.ctrl.addr_sel = AS_IJ;
        uc.ctrl.mem_re   = 1'b1;
        uc.ctrl.lat_kj   = 1'b1;
        uc.jc            = JC_NEXT;
      end
      S_UPD: begin
        uc.ctrl.upd_we  = 1'b1;
        uc.ctrl.cnt_adv = 1'b1;
        uc.jc           = JC_MORE;
        uc.target       = S_RIK;
      end
      S_DONE: begin
        uc.ctrl.emit_done = 1'b1;
        uc.jc             = JC_ALWAYS;
        uc.target         = S_IDLE;
      end
      S_RD: begin
        uc.ctrl.emit_rd = 1'b1;
        uc.jc           = JC_ALWAYS;
        uc.target       = S_IDLE;
      end
      default: begin
        uc.jc     = JC_ALWAYS;
        uc.target = S_IDLE;
      end
    endcase
    return uc;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/apsp_useq.sv @@
// apsp_useq: step counter and jump logic over the control ROM.
// Depends on apsp_pkg.
`default_nettype none

module apsp_useq (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_acc_i,
  input  wire logic [1:0]     cmd_i,
  input  wire apsp_pkg::stat_t stat_i,
  output apsp_pkg::ctrl_t     ctrl_o,
  output logic                in_stall_o
);

  logic [apsp_pkg::StepW-1:0] step_q, step_d;
  apsp_pkg::ucode_t           uc;

  assign uc         = apsp_pkg::ucode_rom(step_q);
  assign ctrl_o     = uc.ctrl;
  assign in_stall_o = ~uc.ctrl.host;

  always_comb begin
    step_d = step_q;
    case (uc.jc)
      apsp_pkg::JC_NEXT:   step_d = step_q + 1'b1;
      apsp_pkg::JC_ALWAYS: step_d = uc.target;
      apsp_pkg::JC_ZERO:   step_d = stat_i.n_zero ? uc.target : step_q + 1'b1;
      apsp_pkg::JC_MORE:   step_d = stat_i.loop_more ? uc.target : step_q + 1'b1;
      apsp_pkg::JC_DISPATCH: begin
        if (in_acc_i && cmd_i == apsp_pkg::CMD_RUN) begin
          step_d = apsp_pkg::S_INIT;
        end else if (in_acc_i && cmd_i == apsp_pkg::CMD_READ) begin
          step_d = apsp_pkg::S_RD;
        end
      end
      default: step_d = apsp_pkg::S_IDLE;
    endcase
    // a result step waits for room in the output register
    if ((uc.ctrl.emit_rd || uc.ctrl.emit_done) && !stat_i.out_free) begin
      step_d = step_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= apsp_pkg::S_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/apsp_dpath.sv @@
// apsp_dpath: distance memory, k/i/j counters, saturating relax unit and
// output register. Driven by the control word of apsp_useq; uses apsp_pkg.
`default_nettype none

module apsp_dpath #(
  parameter int MAX_VERTICES = 16
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire apsp_pkg::ctrl_t                       ctrl_i,
  input  wire logic                                  in_acc_i,
  input  wire logic [1:0]                            cmd_i,
  input  wire logic [3:0]                            row_i,
  input  wire logic [3:0]                            col_i,
  input  wire logic [11:0]                           weight_i,
  input  wire logic                                  no_edge_i,
  input  wire logic [$clog2(MAX_VERTICES+1)-1:0]     n_vert_i,
  output apsp_pkg::stat_t                            stat_o,
  output logic                                       out_valid_o,
  input  wire logic                                  out_stall_i,
  output logic [apsp_pkg::DistW-1:0]                 distance_o,
  output logic                                       unreachable_o,
  output logic                                       is_done_o
);

  localparam int VIW   = $clog2(MAX_VERTICES);
  localparam int NW    = $clog2(MAX_VERTICES + 1);
  localparam int Depth = MAX_VERTICES * MAX_VERTICES;
  localparam int AW    = $clog2(Depth);
  localparam int EW    = apsp_pkg::EntryW;
  localparam int DW    = apsp_pkg::DistW;

  function automatic logic [AW-1:0] cell_addr(input logic [VIW-1:0] r,
                                              input logic [VIW-1:0] c);
    return AW'(AW'(r) * AW'(MAX_VERTICES) + AW'(c));
  endfunction

  logic [EW-1:0]  mem [Depth];
  logic [EW-1:0]  rdata_q;
  logic [EW-1:0]  ik_q, kj_q;
  logic [VIW-1:0] k_q, i_q, j_q;
  logic [VIW-1:0] last_idx;
  logic           oor_q;

  logic           in_range;
  logic [VIW-1:0] h_row, h_col;
  logic [AW-1:0]  host_addr, raddr, waddr;
  logic [EW-1:0]  wdata;
  logic           host_we, mem_we;
  logic [DW:0]    via_sum;
  logic [DW-1:0]  via;
  logic           improve;
  logic           out_free, emit;
  logic           rd_unr;

  // host side addressing; out-of-range pairs fall back to entry zero
  assign in_range  = (int'(row_i) < MAX_VERTICES) && (int'(col_i) < MAX_VERTICES);
  assign h_row     = in_range ? VIW'(row_i) : '0;
  assign h_col     = in_range ? VIW'(col_i) : '0;
  assign host_addr = cell_addr(h_row, h_col);
  assign host_we   = in_acc_i && cmd_i == apsp_pkg::CMD_LOAD && in_range;

  always_comb begin
    case (ctrl_i.addr_sel)
      apsp_pkg::AS_HOST: raddr = host_addr;
      apsp_pkg::AS_IK:   raddr = cell_addr(i_q, k_q);
      apsp_pkg::AS_KJ:   raddr = cell_addr(k_q, j_q);
      apsp_pkg::AS_IJ:   raddr = cell_addr(i_q, j_q);
      default:           raddr = host_addr;
    endcase
  end

  // relax: rdata_q holds the old (i,j) entry during the update step
  assign via_sum = {1'b0, ik_q[DW-1:0]} + {1'b0, kj_q[DW-1:0]};
  assign via     = via_sum[DW] ? {DW{1'b1}} : via_sum[DW-1:0];
  assign improve = !ik_q[DW] && !kj_q[DW] && (rdata_q[DW] || via < rdata_q[DW-1:0]);

  assign mem_we = host_we || (ctrl_i.upd_we && improve);
  assign waddr  = host_we ? host_addr : cell_addr(i_q, j_q);
  assign wdata  = host_we ? (no_edge_i ? {1'b1, {DW{1'b0}}} : {1'b0, 4'd0, weight_i})
                          : {1'b0, via};

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    if (ctrl_i.mem_re) begin
      rdata_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.lat_ik) begin
      ik_q <= rdata_q;
    end
    if (ctrl_i.lat_kj) begin
      kj_q <= rdata_q;
    end
    if (in_acc_i) begin
      oor_q <= !in_range;
    end
  end

  // j innermost, then i, then k
  assign last_idx = VIW'(n_vert_i - NW'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q <= '0;
      i_q <= '0;
      j_q <= '0;
    end else if (ctrl_i.cnt_clr) begin
      k_q <= '0;
      i_q <= '0;
      j_q <= '0;
    end else if (ctrl_i.cnt_adv) begin
      if (j_q != last_idx) begin
        j_q <= j_q + 1'b1;
      end else begin
        j_q <= '0;
        if (i_q != last_idx) begin
          i_q <= i_q + 1'b1;
        end else begin
          i_q <= '0;
          k_q <= k_q + 1'b1;
        end
      end
    end
  end

  assign stat_o.n_zero    = (n_vert_i == '0);
  assign stat_o.loop_more = !((j_q == last_idx) && (i_q == last_idx) && (k_q == last_idx));
  assign stat_o.out_free  = out_free;

  // output register
  assign out_free = !out_valid_o || !out_stall_i;
  assign emit     = (ctrl_i.emit_rd || ctrl_i.emit_done) && out_free;
  assign rd_unr   = oor_q || rdata_q[DW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (emit) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      is_done_o     <= ctrl_i.emit_done;
      unreachable_o <= ctrl_i.emit_rd && rd_unr;
      distance_o    <= (ctrl_i.emit_rd && !rd_unr) ? rdata_q[DW-1:0] : '0;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/all_pairs_shortest_path.sv @@
// all_pairs_shortest_path: top level; vertex count register, sequencer and
// datapath. Depends on apsp_pkg, apsp_useq and apsp_dpath.
//
//  channel  direction  handshake          payload
//  in       input      in_valid / stall   cmd, row, col, weight, no_edge
//  out      output     out_valid / stall  distance, unreachable, is_done
//  cfg      input      cfg_valid / ready  vertex_count (5 bits)
//
// Load: written to the matrix on acceptance. Read: the entry goes through the
// memory read register to the output register. Run: each update needs three
// reads through the single memory read port plus the write-back step.
// Reset clears control state and sets the vertex count to 16; the matrix holds no data until loaded.
// A full output register holds the sequencer in its result step; the input
// stays stalled meanwhile.
`default_nettype none

module all_pairs_shortest_path #(
  parameter int MAX_VERTICES = 16
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic [1:0]                   cmd_i,
  input  wire logic [3:0]                   row_i,
  input  wire logic [3:0]                   col_i,
  input  wire logic [11:0]                  weight_i,
  input  wire logic                         no_edge_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic [apsp_pkg::DistW-1:0]        distance_o,
  output logic                              unreachable_o,
  output logic                              is_done_o,
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [4:0]                   cfg_data_i
);

  localparam int NW = $clog2(MAX_VERTICES + 1);

  logic [4:0]      vc_q;
  logic [NW-1:0]   n_vert;
  logic            in_acc;
  apsp_pkg::ctrl_t ctrl;
  apsp_pkg::stat_t stat;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= 5'd16;
    end else if (cfg_valid_i && cfg_ready_o) begin
      vc_q <= cfg_data_i;
    end
  end

  // counts beyond the matrix size saturate
  assign n_vert = (int'(vc_q) > MAX_VERTICES) ? NW'(MAX_VERTICES) : NW'(vc_q);
  assign in_acc = in_valid_i && !in_stall_o;

  apsp_useq u_useq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_acc_i   (in_acc),
    .cmd_i      (cmd_i),
    .stat_i     (stat),
    .ctrl_o     (ctrl),
    .in_stall_o (in_stall_o)
  );

  apsp_dpath #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (ctrl),
    .in_acc_i      (in_acc),
    .cmd_i         (cmd_i),
    .row_i         (row_i),
    .col_i         (col_i),
    .weight_i      (weight_i),
    .no_edge_i     (no_edge_i),
    .n_vert_i      (n_vert),
    .stat_o        (stat),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .distance_o    (distance_o),
    .unreachable_o (unreachable_o),
    .is_done_o     (is_done_o)
  );

endmodule

`default_nettype wire

@@ rtl/core/apsp_checker.sv @@
// apsp_checker: port-level assertions for all_pairs_shortest_path, bound to
// the top level. Depends on apsp_pkg.
`default_nettype none

module apsp_checker (
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  in_valid_i,
  input wire logic                  in_stall_o,
  input wire logic [1:0]            cmd_i,
  input wire logic                  out_valid_o,
  input wire logic                  out_stall_i,
  input wire logic [apsp_pkg::DistW-1:0] distance_o,
  input wire logic                  unreachable_o,
  input wire logic                  is_done_o
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(distance_o)
      && $stable(unreachable_o) && $stable(is_done_o))
    else $error("stalled result changed");

  a_done_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_done_o |-> !unreachable_o && distance_o == '0)
    else $error("done result carries read fields");

  a_unr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && unreachable_o |-> distance_o == '0 && !is_done_o)
    else $error("unreachable result with nonzero distance");

  // a run or read transaction stalls the input in the cycle after it is accepted
  a_busy_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o
      && (cmd_i == apsp_pkg::CMD_RUN || cmd_i == apsp_pkg::CMD_READ)
      |=> in_stall_o)
    else $error("input taken while a run or read is pending");

endmodule

bind all_pairs_shortest_path apsp_checker u_apsp_checker (.*);

`default_nettype wire
